// File: design/drsc_pkg.sv
// Shared types and constants for the distinct row set counter.
`timescale 1ns / 1ps

package drsc_pkg;

    localparam int MAX_PEOPLE = 128;
    localparam int MAX_TREES  = 64;

    localparam int PERSON_W   = 8;
    localparam int TREE_W     = 7;
    localparam int OP_W       = 2;
    localparam int OUT_W      = 8;
    localparam int ROW_W      = MAX_TREES;
    localparam int ROW_AW     = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
    localparam int CNT_W      = $clog2(MAX_PEOPLE + 1);
    localparam int TREE_IDX_W = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int STEP_W     = 4;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK   = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    // Microprogram step addresses.
    localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CLEAR   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MARK_RD = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MARK_WR = 4'd3;
    localparam logic [STEP_W-1:0] STEP_FIN     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_A_CHK   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_A_LATCH = 4'd6;
    localparam logic [STEP_W-1:0] STEP_B_CHK   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_B_CMP   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_NEXT_A  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd10;
    localparam logic [STEP_W-1:0] STEP_NEW     = 4'd11;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_BRANCH,
        SEQ_WAIT,
        SEQ_DISPATCH
    } seq_t;

    typedef enum logic [2:0] {
        TEST_NONE,
        TEST_MARK_BAD,
        TEST_A_DONE,
        TEST_B_DONE,
        TEST_NO_MATCH,
        TEST_OUT_FREE
    } test_t;

    typedef struct packed {
        logic take_in;
        logic clear;
        logic rd_mark;
        logic wr_mark;
        logic fin_init;
        logic rd_a;
        logic ld_row_a;
        logic rd_b;
        logic inc_b;
        logic inc_a;
        logic inc_tally;
        logic ld_out;
    } act_t;

    typedef struct packed {
        seq_t              seq;
        test_t             test;
        logic [STEP_W-1:0] target;
        act_t              act;
    } uword_t;

    typedef struct packed {
        logic mark_bad;
        logic a_done;
        logic b_done;
        logic no_match;
        logic out_free;
    } status_t;

endpackage

// File: design/distinct_row_set_counter.sv
// Top level: configuration registers, sequencer and datapath.
// A clear beat runs the clear step; a mark beat runs a read step and, unless it is bad, a write step.
// Finish reads rows through the single store port and compares each member's row with every
// earlier row until a match; its run grows with the members N, distinct rows D and compares.
// The result sits in an output register, so marks may be accepted while it waits.
// rst_n clears control state, configuration registers and row valid bits; no clearing pass.
`timescale 1ns / 1ps

module distinct_row_set_counter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [drsc_pkg::OP_W-1:0]      operation,
    input  logic [drsc_pkg::PERSON_W-1:0]  person,
    input  logic [drsc_pkg::TREE_W-1:0]    tree,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [drsc_pkg::OUT_W-1:0]     distinct_count
);
    import drsc_pkg::*;

    localparam logic REG_PEOPLE = 1'b0;
    localparam logic REG_TREE   = 1'b1;

    logic [PERSON_W-1:0] people_count_reg;
    logic [PERSON_W-1:0] people_count_next;
    logic [TREE_W-1:0]   tree_count_reg;
    logic [TREE_W-1:0]   tree_count_next;
    logic                cfg_wr;
    logic                accept;
    act_t                act;
    status_t             status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        people_count_next = people_count_reg;
        tree_count_next   = tree_count_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_PEOPLE: people_count_next = pwdata[PERSON_W-1:0];
                REG_TREE:   tree_count_next   = pwdata[TREE_W-1:0];
                default:    people_count_next = people_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            people_count_reg <= '0;
            tree_count_reg   <= '0;
        end
        else
        begin
            people_count_reg <= people_count_next;
            tree_count_reg   <= tree_count_next;
        end
    end

    assign prdata = (paddr[2] == REG_TREE) ? 32'(tree_count_reg) : 32'(people_count_reg);

    assign in_ready = act.take_in;
    assign accept   = in_valid && in_ready;

    drsc_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .status    (status),
        .act       (act)
    );

    drsc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .act            (act),
        .accept         (accept),
        .person         (person),
        .tree           (tree),
        .people_count   (people_count_reg),
        .tree_count     (tree_count_reg),
        .out_ready      (out_ready),
        .status         (status),
        .out_valid      (out_valid),
        .distinct_count (distinct_count)
    );

endmodule

// File: design/drsc_row_store.sv
// Row store memory with per-row valid bits so that a clear needs no pass over the rows.
`timescale 1ns / 1ps

module drsc_row_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         rd_en,
    input  logic [drsc_pkg::ROW_AW-1:0]  rd_addr,
    input  logic                         wr_en,
    input  logic [drsc_pkg::ROW_AW-1:0]  wr_addr,
    input  logic [drsc_pkg::ROW_W-1:0]   wr_data,
    output logic [drsc_pkg::ROW_W-1:0]   rd_data
);
    import drsc_pkg::*;

    logic [ROW_W-1:0]      row_mem [MAX_PEOPLE];
    logic [ROW_W-1:0]      rd_data_reg;
    logic                  rd_valid_reg;
    logic                  rd_valid_next;
    logic [MAX_PEOPLE-1:0] valid_reg;
    logic [MAX_PEOPLE-1:0] valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (rd_en)
        begin
            rd_valid_next = valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_mem[rd_addr];
        end
    end

    // A row never written since the last clear reads as zero.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: design/drsc_sequencer.sv
// Microprogram ROM and step counter with conditional jumps and op dispatch.
`timescale 1ns / 1ps

module drsc_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [drsc_pkg::OP_W-1:0]   operation,
    input  drsc_pkg::status_t           status,
    output drsc_pkg::act_t              act
);
    import drsc_pkg::*;

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    uword_t            uword;
    logic              cond;

    function automatic uword_t rom(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '0;
        w.seq  = SEQ_NEXT;
        w.test = TEST_NONE;
        unique case (step)
            STEP_IDLE:
            begin
                w.seq         = SEQ_DISPATCH;
                w.act.take_in = 1'b1;
            end
            STEP_CLEAR:
            begin
                w.seq       = SEQ_JUMP;
                w.target    = STEP_IDLE;
                w.act.clear = 1'b1;
            end
            STEP_MARK_RD:
            begin
                w.seq         = SEQ_BRANCH;
                w.test        = TEST_MARK_BAD;
                w.target      = STEP_IDLE;
                w.act.rd_mark = 1'b1;
            end
            STEP_MARK_WR:
            begin
                w.seq         = SEQ_JUMP;
                w.target      = STEP_IDLE;
                w.act.wr_mark = 1'b1;
            end
            STEP_FIN:
            begin
                w.act.fin_init = 1'b1;
            end
            STEP_A_CHK:
            begin
                w.seq      = SEQ_BRANCH;
                w.test     = TEST_A_DONE;
                w.target   = STEP_EMIT;
                w.act.rd_a = 1'b1;
            end
            STEP_A_LATCH:
            begin
                w.act.ld_row_a = 1'b1;
            end
            STEP_B_CHK:
            begin
                w.seq      = SEQ_BRANCH;
                w.test     = TEST_B_DONE;
                w.target   = STEP_NEW;
                w.act.rd_b = 1'b1;
            end
            STEP_B_CMP:
            begin
                // A mismatch moves on to the next earlier row; a match
                // falls through and skips this row as a duplicate without counting it.
                w.seq       = SEQ_BRANCH;
                w.test      = TEST_NO_MATCH;
                w.target    = STEP_B_CHK;
                w.act.inc_b = 1'b1;
            end
            STEP_NEXT_A:
            begin
                w.seq       = SEQ_JUMP;
                w.target    = STEP_A_CHK;
                w.act.inc_a = 1'b1;
            end
            STEP_EMIT:
            begin
                w.seq        = SEQ_WAIT;
                w.test       = TEST_OUT_FREE;
                w.target     = STEP_IDLE;
                w.act.ld_out = 1'b1;
            end
            STEP_NEW:
            begin
                w.seq           = SEQ_JUMP;
                w.target        = STEP_A_CHK;
                w.act.inc_a     = 1'b1;
                w.act.inc_tally = 1'b1;
            end
            default:
            begin
                w.seq    = SEQ_JUMP;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    assign uword = rom(pc_reg);
    assign act   = uword.act;

    always_comb
    begin
        unique case (uword.test)
            TEST_NONE:     cond = 1'b0;
            TEST_MARK_BAD: cond = status.mark_bad;
            TEST_A_DONE:   cond = status.a_done;
            TEST_B_DONE:   cond = status.b_done;
            TEST_NO_MATCH: cond = status.no_match;
            TEST_OUT_FREE: cond = status.out_free;
            default:       cond = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg + 4'd1;
        unique case (uword.seq)
            SEQ_NEXT:   pc_next = pc_reg + 4'd1;
            SEQ_JUMP:   pc_next = uword.target;
            SEQ_BRANCH: pc_next = cond ? uword.target : pc_reg + 4'd1;
            SEQ_WAIT:   pc_next = cond ? uword.target : pc_reg;
            SEQ_DISPATCH:
            begin
                pc_next = pc_reg;
                if (accept)
                begin
                    case (operation)
                        OP_CLEAR:  pc_next = STEP_CLEAR;
                        OP_MARK:   pc_next = STEP_MARK_RD;
                        OP_FINISH: pc_next = STEP_FIN;
                        default:   pc_next = STEP_IDLE;
                    endcase
                end
            end
            default:    pc_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: design/drsc_datapath.sv
// Datapath: beat capture, row indices, row compare, tally and result register.
`timescale 1ns / 1ps

module drsc_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  drsc_pkg::act_t                 act,
    input  logic                           accept,
    input  logic [drsc_pkg::PERSON_W-1:0]  person,
    input  logic [drsc_pkg::TREE_W-1:0]    tree,
    input  logic [drsc_pkg::PERSON_W-1:0]  people_count,
    input  logic [drsc_pkg::TREE_W-1:0]    tree_count,
    input  logic                           out_ready,
    output drsc_pkg::status_t              status,
    output logic                           out_valid,
    output logic [drsc_pkg::OUT_W-1:0]     distinct_count
);
    import drsc_pkg::*;

    logic [PERSON_W-1:0]   person_reg;
    logic [PERSON_W-1:0]   person_next;
    logic [TREE_W-1:0]     tree_reg;
    logic [TREE_W-1:0]     tree_next;
    logic [CNT_W-1:0]      a_reg;
    logic [CNT_W-1:0]      a_next;
    logic [CNT_W-1:0]      b_reg;
    logic [CNT_W-1:0]      b_next;
    logic [CNT_W-1:0]      members_reg;
    logic [CNT_W-1:0]      members_next;
    logic [CNT_W-1:0]      tally_reg;
    logic [CNT_W-1:0]      tally_next;
    logic [ROW_W-1:0]      mask_reg;
    logic [ROW_W-1:0]      mask_next;
    logic [ROW_W-1:0]      row_a_reg;
    logic [ROW_W-1:0]      row_a_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_W-1:0]      out_data_reg;
    logic [OUT_W-1:0]      out_data_next;

    logic [ROW_W-1:0]      rd_data;
    logic [ROW_W-1:0]      wr_data;
    logic [ROW_AW-1:0]     mark_addr;
    logic [ROW_AW-1:0]     rd_addr;
    logic [TREE_IDX_W-1:0] tree_idx;
    logic                  rd_en;
    logic                  out_free;

    assign mark_addr = ROW_AW'(person_reg - 8'd1);
    assign tree_idx  = TREE_IDX_W'(tree_reg - 7'd1);
    assign wr_data   = rd_data | (ROW_W'(1) << tree_idx);
    assign rd_en     = act.rd_mark | act.rd_a | act.rd_b;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        rd_addr = mark_addr;
        if (act.rd_a)
        begin
            rd_addr = a_reg[ROW_AW-1:0];
        end
        else if (act.rd_b)
        begin
            rd_addr = b_reg[ROW_AW-1:0];
        end
    end

    drsc_row_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (act.clear),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (act.wr_mark),
        .wr_addr (mark_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    always_comb
    begin
        status.mark_bad = (person_reg == '0) || (int'(person_reg) > MAX_PEOPLE) ||
                          (tree_reg == '0) || (int'(tree_reg) > MAX_TREES);
        status.a_done   = (a_reg == members_reg);
        status.b_done   = (b_reg == a_reg);
        status.no_match = (((row_a_reg ^ rd_data) & mask_reg) != '0);
        status.out_free = out_free;
    end

    always_comb
    begin
        person_next    = person_reg;
        tree_next      = tree_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        members_next   = members_reg;
        tally_next     = tally_reg;
        mask_next      = mask_reg;
        row_a_next     = row_a_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (accept)
        begin
            person_next = person;
            tree_next   = tree;
        end
        if (act.fin_init)
        begin
            a_next     = '0;
            tally_next = '0;
            if (int'(people_count) > MAX_PEOPLE)
            begin
                members_next = CNT_W'(MAX_PEOPLE);
            end
            else
            begin
                members_next = CNT_W'(people_count);
            end
            for (int i = 0; i < ROW_W; i++)
            begin
                mask_next[i] = (int'(tree_count) > i);
            end
        end
        if (act.rd_a)
        begin
            b_next = '0;
        end
        if (act.ld_row_a)
        begin
            row_a_next = rd_data;
        end
        if (act.inc_b)
        begin
            b_next = b_reg + 1'b1;
        end
        if (act.inc_a)
        begin
            a_next = a_reg + 1'b1;
        end
        if (act.inc_tally)
        begin
            tally_next = tally_reg + 1'b1;
        end
        if (act.ld_out && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_W'(tally_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= '0;
            b_reg         <= '0;
            members_reg   <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_reg         <= a_next;
            b_reg         <= b_next;
            members_reg   <= members_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        person_reg   <= person_next;
        tree_reg     <= tree_next;
        mask_reg     <= mask_next;
        row_a_reg    <= row_a_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid      = out_valid_reg;
    assign distinct_count = out_data_reg;

endmodule

// File: design/drsc_checker.sv
// Port-level checker for the distinct row set counter, bound to the top level.
`timescale 1ns / 1ps

module drsc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [drsc_pkg::OP_W-1:0]      operation,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [drsc_pkg::OUT_W-1:0]     distinct_count
);
    import drsc_pkg::*;

    // A result beat that is not taken holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distinct_count))
        else $error("result beat changed while stalled");

    // A finish beat always occupies the block for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == OP_FINISH |=> !in_ready)
        else $error("input taken right after a finish beat");

    // A clear beat makes the block busy for the clear step only, then ready again.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == OP_CLEAR |=> !in_ready ##1 in_ready)
        else $error("clear beat did not take exactly one busy cycle");

    // No more distinct rows than rows in the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(distinct_count) <= MAX_PEOPLE)
        else $error("distinct count exceeds the row count");

endmodule

bind distinct_row_set_counter drsc_checker u_drsc_checker (.*);
